// ===== src/wscc_pkg.sv =====
// ----------------------------------------------------------------------------
// wscc_pkg
// Types, constants and helpers for the windowed signal classifier.
// ----------------------------------------------------------------------------
package wscc_pkg;

    localparam int CHANNELS_DEF = 4;
    localparam int WINDOW_DEF   = 100;
    localparam int MIN_FILL_DEF = 10;

    localparam int CFG_AW = 4;
    localparam int CFG_DW = 32;

    localparam logic [1:0] REG_AUDIO_PEAK_MIN = 2'd0;
    localparam logic [1:0] REG_AUDIO_VAR_MIN  = 2'd1;
    localparam logic [1:0] REG_CV_LEVEL_MIN   = 2'd2;
    localparam logic [1:0] REG_CV_VAR_MAX     = 2'd3;

    localparam logic [15:0] AUDIO_PEAK_MIN_RST = 16'd205;
    localparam logic [30:0] AUDIO_VAR_MIN_RST  = 31'd4194;
    localparam logic [15:0] CV_LEVEL_MIN_RST   = 16'd2;
    localparam logic [30:0] CV_VAR_MAX_RST     = 31'd41943;

    localparam logic [1:0] CLS_WARMUP = 2'd0;
    localparam logic [1:0] CLS_AUDIO  = 2'd1;
    localparam logic [1:0] CLS_CV     = 2'd2;
    localparam logic [1:0] CLS_NONE   = 2'd3;

    localparam logic [15:0] ONE_VOLT  = 16'd2048;
    localparam logic [15:0] FIVE_VOLT = 16'd10240;
    localparam logic [14:0] TEN_VOLT  = 15'd20480;

    typedef struct packed {
        logic [1:0]         channel;
        logic signed [15:0] sample;
    } t_in_word;

    typedef struct packed {
        logic [14:0] cv_level;
        logic [1:0]  signal_class;
    } t_out_word;

    function automatic logic [14:0] clamp_level(input logic signed [19:0] v);
        logic [14:0] res;
        if (v < 0) begin
            res = '0;
        end else if (v > $signed({5'd0, TEN_VOLT})) begin
            res = TEN_VOLT;
        end else begin
            res = v[14:0];
        end
        return res;
    endfunction

endpackage

// ===== src/wscc_ram.sv =====
// ----------------------------------------------------------------------------
// wscc_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module wscc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [2**AW];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/wscc_smul.sv =====
// ----------------------------------------------------------------------------
// wscc_smul
// Shared shift-and-add multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module wscc_smul #(
    parameter int PW = 46
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [PW-1:0] i_a,
    input  logic [PW-1:0] i_b,
    output logic          o_done,
    output logic [PW-1:0] o_prod
);

    logic          r_busy;
    logic [PW-1:0] r_a;
    logic [PW-1:0] r_b;
    logic [PW-1:0] r_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
        end else if (r_busy && r_b == '0) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a   <= i_a;
            r_b   <= i_b;
            r_acc <= '0;
        end else if (r_busy && r_b != '0) begin
            if (r_b[0]) begin
                r_acc <= r_acc + r_a;
            end
            r_a <= {r_a[PW-2:0], 1'b0};
            r_b <= {1'b0, r_b[PW-1:1]};
        end
    end

    assign o_done = r_busy && (r_b == '0);
    assign o_prod = r_acc;

endmodule

// ===== src/windowed_signal_classifier_cv_scaler.sv =====
// ----------------------------------------------------------------------------
// windowed_signal_classifier_cv_scaler
// Per-channel sliding window statistics, classification and CV scaling.
// ----------------------------------------------------------------------------
//  port group | handshake          | word
//  -----------+--------------------+-------------------------------
//  input      | i_valid / o_stall  | i_word (channel, sample)
//  output     | o_valid / i_stall  | o_word (cv_level, signal_class)
//  config     | APB psel/penable   | paddr, pwdata, prdata
//
//  Each word is processed fully before the next is accepted. During warm-up it
//  is written to the window and passed on; otherwise a window walk (one RAM
//  read per held sample) is followed by five passes through the shift-add
//  multiplier.
//  o_stall is high while busy and while a finished word waits on i_stall.
//  Reset is synchronous; the window RAM needs no clearing.
//  A finished word waits in the output register while the next is accepted.
// ----------------------------------------------------------------------------
module windowed_signal_classifier_cv_scaler
    import wscc_pkg::*;
#(
    parameter int CHANNELS = CHANNELS_DEF,
    parameter int WINDOW   = WINDOW_DEF,
    parameter int MIN_FILL = MIN_FILL_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  t_in_word          i_word,
    output logic              o_valid,
    input  logic              i_stall,
    output t_out_word         o_word,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [CFG_AW-1:0] paddr,
    input  logic [CFG_DW-1:0] pwdata,
    output logic [CFG_DW-1:0] prdata,
    output logic              pready
);

    localparam int CW  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int NW  = $clog2(WINDOW + 1);
    localparam int WPW = $clog2(WINDOW);
    localparam int AW  = $clog2(CHANNELS * WINDOW);
    localparam int SW  = 16 + NW;
    localparam int QW  = 32 + NW;
    localparam int PW  = 32 + 2 * NW;
    localparam int MW  = NW + WPW;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_WR   = 3'd1;
    localparam logic [2:0] S_ACC  = 3'd2;
    localparam logic [2:0] S_MST  = 3'd3;
    localparam logic [2:0] S_MWT  = 3'd4;
    localparam logic [2:0] S_FIN  = 3'd5;

    localparam logic [2:0] M_NSQ = 3'd0;
    localparam logic [2:0] M_SSQ = 3'd1;
    localparam logic [2:0] M_NN  = 3'd2;
    localparam logic [2:0] M_AUD = 3'd3;
    localparam logic [2:0] M_CV  = 3'd4;

    logic [2:0]  r_state, n_state;
    logic [2:0]  r_step;
    logic [15:0] r_apm, r_clm;
    logic [30:0] r_avmin, r_cvmax;

    logic [CW-1:0]       r_ch;
    logic signed [15:0]  r_sample;
    logic [15:0]         r_abs;
    logic [AW-1:0]       r_base;
    logic [NW-1:0]       r_n, r_ri;
    logic                r_p1, r_p2;
    logic [SW-1:0]       r_sum;
    logic [QW-1:0]       r_sumsq;
    logic [31:0]         r_sq;
    logic [15:0]         r_peak;
    logic [PW-1:0]       r_d;
    logic [2*NW-1:0]     r_nn;
    logic                r_aud_var, r_cv_var;
    logic [CHANNELS-1:0] r_mvalid;
    logic                r_ovalid;
    t_out_word           r_out;

    logic [CW-1:0]  in_ch;
    logic           in_acc;
    logic [MW-1:0]  meta_rd, meta_wd;
    logic [NW-1:0]  fill_old, fill_new;
    logic [WPW-1:0] wp_old, wp_new;
    logic [15:0]    win_rd;
    logic [AW-1:0]  win_addr_w, win_addr_r;
    logic           win_we;
    logic           mul_start, mul_done;
    logic [PW-1:0]  mul_a, mul_b, mul_p;
    logic           cfg_we;
    logic [15:0]    in_abs;
    t_out_word      res;
    logic signed [19:0] lv5;

    // channel folded into range
    always_comb begin
        logic [2:0] v;
        v = {1'b0, i_word.channel};
        for (int k = 0; k < 4; k++) begin
            if (32'(v) >= CHANNELS) begin
                v = v - 3'(CHANNELS);
            end
        end
        in_ch = CW'(v);
    end

    assign in_abs = i_word.sample[15] ? 16'(-i_word.sample) : 16'(i_word.sample);
    assign in_acc = i_valid && !o_stall;
    assign o_stall = (r_state != S_IDLE);

    // configuration
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_apm   <= AUDIO_PEAK_MIN_RST;
            r_avmin <= AUDIO_VAR_MIN_RST;
            r_clm   <= CV_LEVEL_MIN_RST;
            r_cvmax <= CV_VAR_MAX_RST;
        end else if (cfg_we) begin
            unique case (paddr[3:2])
                REG_AUDIO_PEAK_MIN: r_apm   <= pwdata[15:0];
                REG_AUDIO_VAR_MIN:  r_avmin <= pwdata[30:0];
                REG_CV_LEVEL_MIN:   r_clm   <= pwdata[15:0];
                REG_CV_VAR_MAX:     r_cvmax <= pwdata[30:0];
                default:            r_apm   <= r_apm;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_AUDIO_PEAK_MIN: prdata = {16'd0, r_apm};
            REG_AUDIO_VAR_MIN:  prdata = {1'b0, r_avmin};
            REG_CV_LEVEL_MIN:   prdata = {16'd0, r_clm};
            REG_CV_VAR_MAX:     prdata = {1'b0, r_cvmax};
            default:            prdata = '0;
        endcase
    end

    // per-channel fill count and write pointer
    wscc_ram #(.WIDTH(MW), .DEPTH(CHANNELS), .AW(CW)) u_meta (
        .i_clk   (i_clk),
        .i_we    (r_state == S_WR),
        .i_waddr (r_ch),
        .i_wdata (meta_wd),
        .i_raddr (in_ch),
        .o_rdata (meta_rd)
    );

    assign fill_old = r_mvalid[r_ch] ? meta_rd[MW-1:WPW] : '0;
    assign wp_old   = r_mvalid[r_ch] ? meta_rd[WPW-1:0]  : '0;
    assign wp_new   = (32'(wp_old) == WINDOW - 1) ? '0 : wp_old + 1'b1;
    assign fill_new = (32'(fill_old) < WINDOW) ? fill_old + 1'b1 : fill_old;
    assign meta_wd  = {fill_new, wp_new};

    // window store
    assign win_we     = (r_state == S_WR);
    assign win_addr_w = r_base + AW'(wp_old);
    assign win_addr_r = r_base + AW'(r_ri);

    wscc_ram #(.WIDTH(16), .DEPTH(CHANNELS * WINDOW), .AW(AW)) u_win (
        .i_clk   (i_clk),
        .i_we    (win_we),
        .i_waddr (win_addr_w),
        .i_wdata (r_abs),
        .i_raddr (win_addr_r),
        .o_rdata (win_rd)
    );

    // shared multiplier
    always_comb begin
        unique case (r_step)
            M_NSQ:   begin mul_a = PW'(r_sumsq);   mul_b = PW'(r_n);   end
            M_SSQ:   begin mul_a = PW'(r_sum);     mul_b = PW'(r_sum); end
            M_NN:    begin mul_a = PW'(r_n);       mul_b = PW'(r_n);   end
            M_AUD:   begin mul_a = PW'({1'b0, r_avmin} + 32'd1); mul_b = PW'(r_nn); end
            M_CV:    begin mul_a = PW'(r_cvmax);   mul_b = PW'(r_nn);  end
            default: begin mul_a = '0;             mul_b = '0;         end
        endcase
    end

    assign mul_start = (r_state == S_MST);

    wscc_smul #(.PW(PW)) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_done  (mul_done),
        .o_prod  (mul_p)
    );

    // sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (in_acc) n_state = S_WR;
            S_WR: begin
                n_state = (32'(fill_new) < MIN_FILL) ? S_FIN : S_ACC;
            end
            S_ACC: if (r_ri == r_n && !r_p1 && !r_p2) n_state = S_MST;
            S_MST: n_state = S_MWT;
            S_MWT: begin
                if (mul_done) begin
                    n_state = (r_step == M_CV) ? S_FIN : S_MST;
                end
            end
            S_FIN: if (!r_ovalid || !i_stall) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_mvalid <= '0;
            r_ovalid <= 1'b0;
            r_p1     <= 1'b0;
            r_p2     <= 1'b0;
            r_step   <= M_NSQ;
        end else begin
            r_state <= n_state;
            if (r_state == S_WR) begin
                r_mvalid[r_ch] <= 1'b1;
            end
            r_p1 <= (r_state == S_ACC) && (r_ri != r_n);
            r_p2 <= r_p1;
            if (r_state == S_WR) begin
                r_step <= M_NSQ;
            end else if (r_state == S_MWT && mul_done) begin
                r_step <= r_step + 3'd1;
            end
            if (r_state == S_FIN && (!r_ovalid || !i_stall)) begin
                r_ovalid <= 1'b1;
            end else if (r_ovalid && !i_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_ch     <= in_ch;
            r_sample <= i_word.sample;
            r_abs    <= in_abs;
            r_base   <= AW'(32'(in_ch) * WINDOW);
        end
        if (r_state == S_WR) begin
            r_n     <= fill_new;
            r_ri    <= '0;
            r_sum   <= '0;
            r_sumsq <= '0;
            r_peak  <= '0;
        end
        if (r_state == S_ACC && r_ri != r_n) begin
            r_ri <= r_ri + 1'b1;
        end
        if (r_p1) begin
            r_sum <= r_sum + SW'(win_rd);
            r_sq  <= win_rd * win_rd;
            if (win_rd > r_peak) begin
                r_peak <= win_rd;
            end
        end
        if (r_p2) begin
            r_sumsq <= r_sumsq + QW'(r_sq);
        end
        if (r_state == S_MWT && mul_done) begin
            unique case (r_step)
                M_NSQ:   r_d       <= mul_p;
                M_SSQ:   r_d       <= r_d - mul_p;
                M_NN:    r_nn      <= mul_p[2*NW-1:0];
                M_AUD:   r_aud_var <= (r_d >= mul_p);
                M_CV:    r_cv_var  <= (r_d < mul_p);
                default: r_d       <= r_d;
            endcase
        end
        if (r_state == S_FIN && (!r_ovalid || !i_stall)) begin
            r_out <= res;
        end
    end

    // classification and scaling
    assign lv5 = (20'(r_sample) + 20'sd2048) * 20'sd5;

    always_comb begin
        priority if (32'(r_n) < MIN_FILL) begin
            res.signal_class = CLS_WARMUP;
            res.cv_level     = clamp_level(lv5);
        end else if (r_peak > r_apm && r_aud_var) begin
            res.signal_class = CLS_AUDIO;
            res.cv_level     = clamp_level(lv5);
        end else if (r_abs > r_clm && r_cv_var) begin
            res.signal_class = CLS_CV;
            if (r_peak <= ONE_VOLT) begin
                res.cv_level = clamp_level(lv5);
            end else if (r_peak <= FIVE_VOLT) begin
                res.cv_level = clamp_level(20'(r_sample) * 20'sd2);
            end else begin
                res.cv_level = clamp_level(20'(r_sample));
            end
        end else begin
            res.signal_class = CLS_NONE;
            res.cv_level     = '0;
        end
    end

    assign o_valid = r_ovalid;
    assign o_word  = r_out;

endmodule

// ===== src/wscc_checker.sv =====
// ----------------------------------------------------------------------------
// wscc_checker
// Port-level checks for the windowed signal classifier, bound to the top.
// ----------------------------------------------------------------------------
module wscc_checker
    import wscc_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_valid,
    input logic      o_stall,
    input logic      o_valid,
    input logic      i_stall,
    input t_out_word o_word
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_word)))
        else $error("output word changed while stalled");

    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("input taken without going busy");

    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_word.cv_level <= TEN_VOLT))
        else $error("level above 10 V");

    a_none: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_word.signal_class == CLS_NONE) |-> (o_word.cv_level == '0))
        else $error("no class but nonzero level");

    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_valid && !o_stall))
        else $error("not idle after reset");

endmodule

bind windowed_signal_classifier_cv_scaler wscc_checker u_wscc_checker (.*);
